// File: rtl/core/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg: shared types and constants of the batched release tracker
// Entry status codes, item opcodes, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int DELAY_W     = 32;
	localparam int DECAY_W     = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CNT_W-1:0] DIV_CAP   = 7'd127;
	localparam logic [CNT_W-1:0] TRACK_MAX = CNT_W'(NUM_ENTRIES);

	typedef enum logic [1:0] {
		ST_IN_USE     = 2'd0,
		ST_PENDING    = 2'd1,
		ST_RELEASABLE = 2'd2,
		ST_RELEASED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_FINISHED = 2'd1,
		OP_RELEASED = 2'd2,
		OP_CLOSE    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENTRIES = 2'd0,
		CFG_DECAY   = 2'd1,
		CFG_DELAY   = 2'd2,
		CFG_COORD   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_LOOKUP = 2'd1,
		S_SCAN   = 2'd2
	} state_t;

	typedef struct packed {
		logic             push;
		logic             flush;
		logic [IDX_W-1:0] entry;
		logic             kind;
	} emit_req_t;

endpackage

// File: rtl/core/bra_stat_mem.sv
// ----------------------------------------------------------------------------
// bra_stat_mem: entry status memory
// One write port and one registered read port; entries never written since
// the last clear read back as in use.
// ----------------------------------------------------------------------------
module bra_stat_mem
	import bra_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  status_t          wdata,
	input  logic [IDX_W-1:0] raddr,
	output status_t          rdata
);

	status_t                mem [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] valid_q;
	status_t                rdata_q;
	logic                   rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			rvld_q <= valid_q[raddr];
			if (clear) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : ST_IN_USE;

endmodule

// File: rtl/core/bra_emit.sv
// ----------------------------------------------------------------------------
// bra_emit: list output stage
// Holds the latest list member back by one so that the final member can be
// marked when the scan ends; results leave through registers.
// ----------------------------------------------------------------------------
module bra_emit
	import bra_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  emit_req_t        req,
	output logic             strobe,
	output logic [IDX_W-1:0] out_entry,
	output logic             list_kind,
	output logic             last_of_list
);

	logic             hold_v_q;
	logic [IDX_W-1:0] hold_entry_q;
	logic             hold_kind_q;
	logic             strobe_q;
	logic [IDX_W-1:0] entry_q;
	logic             kind_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= hold_v_q && (req.push || req.flush);
			if (req.push) begin
				hold_v_q <= 1'b1;
			end else if (req.flush) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= hold_entry_q;
		kind_q  <= hold_kind_q;
		last_q  <= !req.push;
		if (req.push) begin
			hold_entry_q <= req.entry;
			hold_kind_q  <= req.kind;
		end
	end

	assign strobe       = strobe_q;
	assign out_entry    = entry_q;
	assign list_kind    = kind_q;
	assign last_of_list = last_q;

endmodule

// File: rtl/core/batched_release_tracker.sv
// ----------------------------------------------------------------------------
// batched_release_tracker: worker entry release tracker
// Tracks each entry as in use, pending, releasable or released, fires batch
// releases and lists in-use and pending entries at close.
// ----------------------------------------------------------------------------
// Timing: a tick leaves busy low; finished items on an open tracker and released
// items that name a tracked entry raise busy for the lookup after the transfer.
// A close, or a finished item that fires a batch, sweeps one entry per cycle with
// busy high (a batch after its lookup); the last result strobes in the cycle busy
// falls. The receiver cannot stall results.
// Reset (arst_n low) brings all entries in use with the register defaults.
// ----------------------------------------------------------------------------
module batched_release_tracker
	import bra_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            opcode,
	input  logic [IDX_W-1:0]      entry_index,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  result_strobe,
	output logic [IDX_W-1:0]      out_entry,
	output logic                  list_kind,
	output logic                  last_of_list
);

	// Configuration registers.
	logic [CNT_W-1:0]   ent_cfg_q;
	logic [DECAY_W-1:0] decay_q;
	logic [DELAY_W-1:0] delay_q;
	logic [IDX_W-1:0]   coord_q;

	// Tracker state.
	state_t             state_q, state_d;
	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	logic               kind_q;
	logic [CNT_W-1:0]   scan_q;
	logic               rvalid_s1;
	logic [IDX_W-1:0]   raddr_s1;
	logic [CNT_W-1:0]   in_use_q;
	logic [CNT_W-1:0]   pend_q;
	logic [DELAY_W-1:0] elapsed_q;
	logic [CNT_W-1:0]   div_q;
	logic               coord_gone_q;
	logic               closed_q;

	// Memory and output stage connections.
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	status_t            mem_wdata;
	logic [IDX_W-1:0]   mem_raddr;
	status_t            rstat;
	emit_req_t          req;

	// Decision terms.
	logic               accept;
	op_t                op_in;
	logic [CNT_W-1:0]   tracked;
	logic               idx_ok;
	logic               restart;
	logic [CNT_W-1:0]   new_ent;
	logic [CNT_W-1:0]   new_tracked;
	logic [DECAY_W-1:0] new_decay;
	logic [CNT_W-1:0]   in_use_dec;
	logic               last_coord;
	logic               timed;
	logic [CNT_W-1:0]   div_eff;
	logic [CNT_W:0]     pend_p2;
	logic [2*CNT_W:0]   thr_prod;
	logic               enough;
	logic [CNT_W+DECAY_W-1:0] decay_prod;
	logic [CNT_W-1:0]   div_next;
	logic               lookup_finish;
	logic               fire;
	logic               scan_issue;
	logic               scan_done;
	logic               scan_match;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign op_in  = op_t'(opcode);

	// The number of tracked entries is the entry register limited to the table.
	assign tracked = (ent_cfg_q > TRACK_MAX) ? TRACK_MAX : ent_cfg_q;
	assign idx_ok  = {1'b0, entry_index} < tracked;

	// Writing the entry count or the decay factor starts a fresh tracker, built
	// from the register values being written in the same cycle.
	assign restart     = cfg_we && ((cfg_index == CFG_ENTRIES) || (cfg_index == CFG_DECAY));
	assign new_ent     = (cfg_index == CFG_ENTRIES) ? cfg_wdata[CNT_W-1:0] : ent_cfg_q;
	assign new_decay   = (cfg_index == CFG_DECAY) ? cfg_wdata[DECAY_W-1:0] : decay_q;
	assign new_tracked = (new_ent > TRACK_MAX) ? TRACK_MAX : new_ent;

	// Batch trigger, evaluated when a finished entry turns pending. The
	// threshold test pending >= max(tracked / div, 1) is rewritten without a
	// divider: with at least one pending entry it holds exactly when
	// tracked < (pending + 1) * div, where pending already counts this entry.
	assign in_use_dec = in_use_q - 1'b1;
	assign last_coord = !coord_gone_q && (in_use_dec == CNT_W'(1));
	assign timed      = elapsed_q > delay_q;
	assign div_eff    = (div_q == '0) ? CNT_W'(1) : div_q;
	assign pend_p2    = {1'b0, pend_q} + (CNT_W+1)'(2);
	assign thr_prod   = {{CNT_W{1'b0}}, pend_p2} * {{(CNT_W+1){1'b0}}, div_eff};
	assign enough     = {{(CNT_W+1){1'b0}}, tracked} < thr_prod;
	assign decay_prod = {{DECAY_W{1'b0}}, div_q} * {{CNT_W{1'b0}}, decay_q};
	assign div_next   = (decay_prod > {{DECAY_W{1'b0}}, DIV_CAP}) ? DIV_CAP
	                    : decay_prod[CNT_W-1:0];

	assign lookup_finish = (op_q == OP_FINISHED) && (rstat == ST_IN_USE);
	assign fire          = lookup_finish && (last_coord || (timed && enough));

	// Sweep: one read issued per cycle, its status comes back the next cycle.
	assign scan_issue = scan_q < tracked;
	assign scan_done  = !scan_issue && !rvalid_s1;
	assign scan_match = kind_q ? ((rstat == ST_IN_USE) || (rstat == ST_PENDING))
	                           : (rstat == ST_PENDING);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_in)
						OP_FINISHED: if (idx_ok && !closed_q) state_d = S_LOOKUP;
						OP_RELEASED: if (idx_ok) state_d = S_LOOKUP;
						OP_CLOSE:    if (tracked != '0) state_d = S_SCAN;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_LOOKUP: begin
				state_d = fire ? S_SCAN : S_IDLE;
			end
			S_SCAN: begin
				if (scan_done) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory port and output stage control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = ST_PENDING;
		mem_raddr = entry_index;
		req       = '0;
		req.entry = raddr_s1;
		req.kind  = kind_q;
		case (state_q)
			S_IDLE: begin
				mem_raddr = entry_index;
			end
			S_LOOKUP: begin
				if (op_q == OP_RELEASED) begin
					mem_we    = 1'b1;
					mem_wdata = ST_RELEASED;
				end else if (lookup_finish) begin
					mem_we    = 1'b1;
					mem_wdata = ST_PENDING;
				end
			end
			S_SCAN: begin
				mem_raddr = scan_q[IDX_W-1:0];
				if (rvalid_s1 && scan_match) begin
					req.push = 1'b1;
					// Batch members become releasable as they are listed.
					if (!kind_q) begin
						mem_we    = 1'b1;
						mem_waddr = raddr_s1;
						mem_wdata = ST_RELEASABLE;
					end
				end
				req.flush = scan_done;
			end
			default: begin
				mem_raddr = entry_index;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ent_cfg_q    <= TRACK_MAX;
			decay_q      <= DECAY_W'(2);
			delay_q      <= DELAY_W'(1000);
			coord_q      <= '0;
			in_use_q     <= TRACK_MAX;
			pend_q       <= '0;
			elapsed_q    <= '0;
			div_q        <= CNT_W'(2);
			coord_gone_q <= 1'b0;
			closed_q     <= 1'b0;
			rvalid_s1    <= 1'b0;
			scan_q       <= '0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= (state_q == S_SCAN) && scan_issue;

			if (cfg_we) begin
				case (cfg_index)
					CFG_ENTRIES: ent_cfg_q <= cfg_wdata[CNT_W-1:0];
					CFG_DECAY:   decay_q   <= cfg_wdata[DECAY_W-1:0];
					CFG_DELAY:   delay_q   <= cfg_wdata[DELAY_W-1:0];
					CFG_COORD:   coord_q   <= cfg_wdata[IDX_W-1:0];
					default:     ;
				endcase
			end

			if (restart) begin
				in_use_q     <= new_tracked;
				pend_q       <= '0;
				elapsed_q    <= '0;
				div_q        <= {{(CNT_W-DECAY_W){1'b0}}, new_decay};
				coord_gone_q <= 1'b0;
				closed_q     <= 1'b0;
			end else begin
				case (state_q)
					S_IDLE: begin
						scan_q <= '0;
						if (accept) begin
							if ((op_in == OP_TICK) && (elapsed_q != '1)) begin
								elapsed_q <= elapsed_q + 1'b1;
							end
							if (op_in == OP_CLOSE) begin
								closed_q <= 1'b1;
							end
						end
					end
					S_LOOKUP: begin
						scan_q <= '0;
						if (op_q == OP_RELEASED) begin
							if (rstat == ST_IN_USE) begin
								in_use_q <= in_use_dec;
							end else if (rstat == ST_PENDING) begin
								pend_q <= pend_q - 1'b1;
							end
							if (idx_q == coord_q) begin
								coord_gone_q <= 1'b1;
							end
						end else if (lookup_finish) begin
							in_use_q <= in_use_dec;
							if (fire) begin
								pend_q    <= '0;
								elapsed_q <= '0;
								div_q     <= div_next;
							end else begin
								pend_q <= pend_q + 1'b1;
							end
						end
					end
					S_SCAN: begin
						if (scan_issue) begin
							scan_q <= scan_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Item and sweep payload registers.
	always_ff @(posedge clk) begin
		raddr_s1 <= scan_q[IDX_W-1:0];
		if (accept) begin
			op_q  <= op_in;
			idx_q <= entry_index;
		end
		if (state_q == S_IDLE) begin
			kind_q <= 1'b1;
		end else if (state_q == S_LOOKUP) begin
			kind_q <= 1'b0;
		end
	end

	bra_stat_mem u_stat_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (restart),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (rstat)
	);

	bra_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.strobe       (result_strobe),
		.out_entry    (out_entry),
		.list_kind    (list_kind),
		.last_of_list (last_of_list)
	);

endmodule
